// File: src/isau_pkg.sv
// shared constants and codes for the integer stack arithmetic unit
`default_nettype none
package isau_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = 7;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = ((OP_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + COUNT_W + STATUS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_ADD  = 2'd1,
    OP_MUL  = 2'd2,
    OP_MOD  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // handshake between sequencer and divider
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DATA_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: src/isau_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none
module isau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: src/isau_div.sv
// iterative signed remainder unit, one quotient bit per cycle
`default_nettype none
module isau_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire isau_pkg::div_req_t       req,
  input  wire logic [isau_pkg::DATA_W-1:0] dividend,
  input  wire logic [isau_pkg::DATA_W-1:0] divisor,
  output isau_pkg::div_rsp_t            rsp
);
  import isau_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIX
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvd;
  logic [DATA_W-1:0] dsr;
  logic              neg;

  logic [DATA_W:0]   partial;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] rem_next;

  always_comb begin
    partial  = {rem, dvd[DATA_W-1]};
    diff     = partial - {1'b0, dsr};
    rem_next = diff[DATA_W] ? partial[DATA_W-1:0] : diff[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == S_FIX);
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            // work on magnitudes, remainder takes the dividend's sign
            neg   <= dividend[DATA_W-1];
            dvd   <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
            dsr   <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
            rem   <= '0;
            cnt   <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          rem <= rem_next;
          dvd <= {dvd[DATA_W-2:0], 1'b0};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DATA_W - 1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          rsp.rem  <= neg ? (DATA_W'(0) - rem) : rem;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/integer_stack_arith_unit_top.sv
// Integer stack calculator: each input transaction pushes a value or pops the top two
// entries and pushes their sum, product or remainder (second % top, truncating, sign of
// the dividend). Refused operations leave the stack unchanged and return a status code.
// The top of stack lives in a register and the entries below it in a ram, so an
// operation needs one ram read. A push or a refused short operation goes straight to the
// output state; add, multiply and modulo pass through the read and execute states, and a
// modulo by a nonzero top then also waits on the divider, one remainder bit per cycle.
// Every input transaction yields exactly one output transaction; the output is held in
// a register so the next input can be taken while a result waits, and a result stalls
// in place until the one before it has been taken.
`default_nettype none
module integer_stack_arith_unit_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // [1:0] action, [33:2] push_value
  input  wire logic [isau_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [31:0] top_value, [38:32] stack_count, [40:39] status
  output logic      [isau_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import isau_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_DONE
  } state_t;

  state_t             state;
  op_t                action;
  status_t            status;
  logic [DATA_W-1:0]  top_reg;
  logic [DEPTH_W-1:0] depth;

  logic               in_fire;
  op_t                in_action;
  logic [DATA_W-1:0]  in_value;
  logic [DEPTH_W-1:0] depth_m1;
  logic [DEPTH_W-1:0] depth_m2;
  logic [DEPTH_W+COUNT_W-1:0] depth_wide;
  logic               out_load;

  logic               wr_en;
  logic [DATA_W-1:0]  rd_data;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign s_tready  = (state == S_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign in_action = op_t'(s_tdata[OP_W-1:0]);
  assign in_value  = s_tdata[OP_W+DATA_W-1:OP_W];
  assign depth_m1  = depth - DEPTH_W'(1);
  assign depth_m2  = depth - DEPTH_W'(2);
  assign depth_wide = {{COUNT_W{1'b0}}, depth};
  assign out_load  = (state == S_DONE) && (!m_tvalid || m_tready);

  // old top moves down into the ram on a push onto a stack that is neither empty nor full
  assign wr_en = in_fire && (in_action == OP_PUSH) &&
                 (depth != DEPTH_W'(STACK_DEPTH)) && (depth != '0);
  assign div_req.start = (state == S_EXEC) && (action == OP_MOD) && (top_reg != '0);

  isau_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(depth_m1[ADDR_W-1:0]),
    .wr_data(top_reg),
    .rd_addr(depth_m2[ADDR_W-1:0]),
    .rd_data(rd_data)
  );

  isau_div u_div (
    .clk     (clk),
    .rst     (rst),
    .req     (div_req),
    .dividend(rd_data),
    .divisor (top_reg),
    .rsp     (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      depth    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            action <= in_action;
            if (in_action == OP_PUSH) begin
              if (depth == DEPTH_W'(STACK_DEPTH)) begin
                status <= ST_FULL;
              end else begin
                status  <= ST_OK;
                top_reg <= in_value;
                depth   <= depth + DEPTH_W'(1);
              end
              state <= S_DONE;
            end else if (depth < DEPTH_W'(2)) begin
              status <= ST_SHORT;
              state  <= S_DONE;
            end else begin
              status <= ST_OK;
              state  <= S_READ;
            end
          end
        end
        S_READ: begin
          // ram read data for the second entry arrives next cycle
          state <= S_EXEC;
        end
        S_EXEC: begin
          unique case (action)
            OP_ADD: begin
              top_reg <= rd_data + top_reg;
              depth   <= depth_m1;
              state   <= S_DONE;
            end
            OP_MUL: begin
              top_reg <= DATA_W'(rd_data * top_reg);
              depth   <= depth_m1;
              state   <= S_DONE;
            end
            OP_MOD: begin
              if (top_reg == '0) begin
                status <= ST_DIVZERO;
                state  <= S_DONE;
              end else begin
                state <= S_DIV;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_DIV: begin
          if (div_rsp.done) begin
            top_reg <= div_rsp.rem;
            depth   <= depth_m1;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            m_tdata  <= {{(OUT_TDATA_W - DATA_W - COUNT_W - STATUS_W){1'b0}},
                         status, depth_wide[COUNT_W-1:0],
                         (depth != '0) ? top_reg : DATA_W'(0)};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
